/* rtl/quaternion_pose_transform_assert.svh */
// Assertion macros used by the pose transform top level.
`ifndef QUATERNION_POSE_TRANSFORM_ASSERT_SVH
`define QUATERNION_POSE_TRANSFORM_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is asserted.
`define QPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked property that is also evaluated during reset.
`define QPT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define QPT_ASSERT(lbl, prop, msg)
`define QPT_ASSERT_RST(lbl, prop, msg)

`endif

`endif

/* rtl/qpt_pkg.sv */
// Types, constants and arithmetic helpers for the pose transform pipeline.
package qpt_pkg;

    typedef logic signed [31:0] t_s32;

    // Number of quotient bits produced by the inverse divider.
    localparam int unsigned DIV_STEPS = 31;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Operation selector codes.
    localparam logic [1:0] FUNC_POINT   = 2'd0;
    localparam logic [1:0] FUNC_COMPOSE = 2'd1;
    localparam logic [1:0] FUNC_INVERT  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TX = 3'd0;
    localparam logic [2:0] CFG_TY = 3'd1;
    localparam logic [2:0] CFG_TZ = 3'd2;
    localparam logic [2:0] CFG_QW = 3'd3;
    localparam logic [2:0] CFG_QX = 3'd4;
    localparam logic [2:0] CFG_QY = 3'd5;
    localparam logic [2:0] CFG_QZ = 3'd6;

    // Sideband that rides along with the divider.
    typedef struct packed {
        logic [1:0]       func;
        logic [2:0][31:0] vec;
        logic [3:0][31:0] quat;
        logic [3:0]       neg;
        logic [3:0]       sat;
        logic             zero;
    } t_div_pay;

    typedef struct packed {
        logic [62:0] rem;
        logic        bit_q;
    } t_div_step;

    // One restoring division step: shift the remainder, subtract if it fits.
    function automatic t_div_step div_step(input logic [62:0] rem, input logic [63:0] den);
        logic [63:0] sh;
        logic [63:0] dif;
        t_div_step   res;
        sh = {rem, 1'b0};
        dif = sh - den;
        res.bit_q = (sh >= den);
        res.rem = res.bit_q ? dif[62:0] : sh[62:0];
        return res;
    endfunction

    // Clamp a 40-bit signed value into 32 bits.
    function automatic t_s32 sat32(input logic signed [39:0] x);
        if (x > 40'sd2147483647) begin
            return S32_MAX;
        end else if (x < -40'sd2147483648) begin
            return S32_MIN;
        end
        return x[31:0];
    endfunction

    // Full-precision 32 by 32 signed product.
    function automatic logic signed [63:0] smul(input t_s32 a, input t_s32 b);
        return a * b;
    endfunction

endpackage

/* rtl/quaternion_pose_transform.sv */
// Top level of the fixed-point quaternion rigid pose transform.
//
// Transforms points, composes poses and inverts poses against a configured pose
// (translation Q16.16, quaternion Q1.30). The pipeline takes one request per clock
// while its skid register is empty; the depth is set by the 31-stage restoring
// divider used for the inverse, which every request passes through so results leave
// in order. A one-entry skid register behind the output catches one result when the
// output is stalled; the pipeline then holds until that entry drains. Configuration
// writes take effect at once and belong to idle periods.
`include "quaternion_pose_transform_assert.svh"

module quaternion_pose_transform (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // in_x, in_y, in_z, in_qw, in_qx, in_qy, in_qz (32 bits each, lowest first)
    input  logic [223:0] i_s_tdata,
    // func
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // out_x, out_y, out_z, out_qw, out_qx, out_qy, out_qz (32 bits each, lowest first)
    output logic [223:0] o_m_tdata,
    // zero_norm
    output logic [0:0]   o_m_tuser,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);
    import qpt_pkg::*;

    logic w_en;

    // Configuration registers.
    t_s32 r_cfg_t [3];
    t_s32 r_cfg_q [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t[0] <= '0;
            r_cfg_t[1] <= '0;
            r_cfg_t[2] <= '0;
            r_cfg_q[0] <= ONE_Q30;
            r_cfg_q[1] <= '0;
            r_cfg_q[2] <= '0;
            r_cfg_q[3] <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_TX: r_cfg_t[0] <= i_cfg_wdata;
                CFG_TY: r_cfg_t[1] <= i_cfg_wdata;
                CFG_TZ: r_cfg_t[2] <= i_cfg_wdata;
                CFG_QW: r_cfg_q[0] <= i_cfg_wdata;
                CFG_QX: r_cfg_q[1] <= i_cfg_wdata;
                CFG_QY: r_cfg_q[2] <= i_cfg_wdata;
                CFG_QZ: r_cfg_q[3] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Valid bits of the stages outside the divider.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic w_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8} <= '0;
        end else if (w_en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= w_dv;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // Stage 1: capture the request.
    logic [1:0] r_f1;
    t_s32       r_p1 [3];
    t_s32       r_b1 [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1 <= i_s_tuser;
            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= i_s_tdata[32*i +: 32];
            end
            for (int i = 0; i < 4; i++) begin
                r_b1[i] <= i_s_tdata[96 + 32*i +: 32];
            end
        end
    end

    // Stage 2: squares of the input quaternion parts.
    logic [1:0]  r_f2;
    t_s32        r_p2 [3];
    t_s32        r_b2 [4];
    logic [62:0] r_sq2 [4];
    logic signed [63:0] n_sq [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_sq[i] = smul(r_b1[i], r_b1[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2 <= r_f1;
            r_p2 <= r_p1;
            r_b2 <= r_b1;
            for (int i = 0; i < 4; i++) begin
                r_sq2[i] <= n_sq[i][62:0];
            end
        end
    end

    // Stage 3: squared norm, dividend magnitudes and signs, early saturation.
    logic [63:0]      r_n3;
    logic [3:0][31:0] r_m3;
    t_div_pay         r_pay3;
    logic [63:0]      n_norm;
    logic [3:0][31:0] n_mag;
    t_div_pay         n_pay;

    always_comb begin
        n_norm = {2'b00, r_sq2[0][62:1]} + {2'b00, r_sq2[1][62:1]}
               + {2'b00, r_sq2[2][62:1]} + {2'b00, r_sq2[3][62:1]};
        n_pay.func = r_f2;
        for (int i = 0; i < 3; i++) begin
            n_pay.vec[i] = r_p2[i];
        end
        for (int i = 0; i < 4; i++) begin
            n_pay.quat[i] = r_b2[i];
            n_mag[i] = r_b2[i][31] ? (~r_b2[i] + 32'd1) : r_b2[i];
            // The scalar part keeps its sign, the vector parts are negated.
            if (i == 0) begin
                n_pay.neg[i] = r_b2[i][31];
            end else begin
                n_pay.neg[i] = !r_b2[i][31] && (r_b2[i] != '0);
            end
            n_pay.sat[i] = ({4'd0, n_mag[i], 28'd0} >= n_norm);
        end
        n_pay.zero = (n_norm == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n3   <= n_norm;
            r_m3   <= n_mag;
            r_pay3 <= n_pay;
        end
    end

    // Divider pipeline for the inverse quaternion.
    logic [63:0]      w_den;
    logic [3:0][62:0] w_rem;
    logic [3:0][30:0] w_quo;
    t_div_pay         w_pay;

    qpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_den   (r_n3),
        .i_mag   (r_m3),
        .i_pay   (r_pay3),
        .o_valid (w_dv),
        .o_den   (w_den),
        .o_rem   (w_rem),
        .o_quo   (w_quo),
        .o_pay   (w_pay)
    );

    // Stage 4: round the quotients, apply sign and saturation.
    logic [1:0] r_f4;
    t_s32       r_p4 [3];
    t_s32       r_b4 [4];
    t_s32       r_oq4 [4];
    logic       r_z4;
    t_s32       n_oq [4];
    logic [31:0] n_qr;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_qr = {1'b0, w_quo[i]} + {31'd0, ({w_rem[i], 1'b0} >= w_den)};
            if (w_pay.zero) begin
                n_oq[i] = '0;
            end else if (w_pay.sat[i]) begin
                n_oq[i] = w_pay.neg[i] ? S32_MIN : S32_MAX;
            end else if (w_pay.neg[i]) begin
                n_oq[i] = ~n_qr + 32'd1;
            end else if (n_qr[31]) begin
                n_oq[i] = S32_MAX;
            end else begin
                n_oq[i] = n_qr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f4 <= w_pay.func;
            r_z4 <= w_pay.zero;
            for (int i = 0; i < 3; i++) begin
                r_p4[i] <= w_pay.vec[i];
            end
            for (int i = 0; i < 4; i++) begin
                r_b4[i]  <= w_pay.quat[i];
                r_oq4[i] <= n_oq[i];
            end
        end
    end

    // Stage 5: products for the rotation matrix and the Hamilton product.
    logic [1:0]         r_f5;
    t_s32               r_p5 [3];
    t_s32               r_oq5 [4];
    logic               r_z5;
    logic signed [63:0] r_rp5 [9];
    logic signed [63:0] r_mp5 [16];
    t_s32               w_rq [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_rq[i] = (r_f4 == FUNC_INVERT) ? r_oq4[i] : r_cfg_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f5  <= r_f4;
            r_p5  <= r_p4;
            r_oq5 <= r_oq4;
            r_z5  <= r_z4;
            r_rp5[0] <= smul(w_rq[1], w_rq[1]);
            r_rp5[1] <= smul(w_rq[2], w_rq[2]);
            r_rp5[2] <= smul(w_rq[3], w_rq[3]);
            r_rp5[3] <= smul(w_rq[1], w_rq[2]);
            r_rp5[4] <= smul(w_rq[3], w_rq[0]);
            r_rp5[5] <= smul(w_rq[1], w_rq[3]);
            r_rp5[6] <= smul(w_rq[2], w_rq[0]);
            r_rp5[7] <= smul(w_rq[2], w_rq[3]);
            r_rp5[8] <= smul(w_rq[1], w_rq[0]);
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_mp5[4*i + j] <= smul(r_cfg_q[i], r_b4[j]);
                end
            end
        end
    end

    // Stage 6: matrix entries and composed quaternion, each saturated.
    logic [1:0]         r_f6;
    t_s32               r_p6 [3];
    t_s32               r_oq6 [4];
    logic               r_z6;
    t_s32               r_m6 [9];
    t_s32               r_qm6 [4];
    logic signed [63:0] w_tr;
    logic signed [34:0] w_tw35;
    logic signed [39:0] w_tw [9];
    logic signed [39:0] w_one;
    t_s32               n_m [9];
    logic signed [65:0] w_qs [4];
    logic signed [65:0] w_qp [16];
    logic signed [65:0] w_qr;
    logic signed [35:0] w_q36;
    t_s32               n_qm [4];

    always_comb begin
        w_one = 40'sd1073741824;
        for (int k = 0; k < 9; k++) begin
            w_tr = r_rp5[k] + 64'sd268435456;
            w_tw35 = w_tr[63:29];
            w_tw[k] = w_tw35;
        end
        n_m[0] = sat32(w_one - w_tw[1] - w_tw[2]);
        n_m[1] = sat32(w_tw[3] - w_tw[4]);
        n_m[2] = sat32(w_tw[5] + w_tw[6]);
        n_m[3] = sat32(w_tw[3] + w_tw[4]);
        n_m[4] = sat32(w_one - w_tw[0] - w_tw[2]);
        n_m[5] = sat32(w_tw[7] - w_tw[8]);
        n_m[6] = sat32(w_tw[5] - w_tw[6]);
        n_m[7] = sat32(w_tw[7] + w_tw[8]);
        n_m[8] = sat32(w_one - w_tw[0] - w_tw[1]);
        for (int k = 0; k < 16; k++) begin
            w_qp[k] = r_mp5[k];
        end
        w_qs[0] = w_qp[0] - w_qp[5] - w_qp[10] - w_qp[15];
        w_qs[1] = w_qp[1] + w_qp[4] + w_qp[11] - w_qp[14];
        w_qs[2] = w_qp[2] - w_qp[7] + w_qp[8] + w_qp[13];
        w_qs[3] = w_qp[3] + w_qp[6] - w_qp[9] + w_qp[12];
        for (int i = 0; i < 4; i++) begin
            w_qr = w_qs[i] + 66'sd536870912;
            w_q36 = w_qr[65:30];
            n_qm[i] = sat32(40'(w_q36));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f6  <= r_f5;
            r_p6  <= r_p5;
            r_oq6 <= r_oq5;
            r_z6  <= r_z5;
            r_m6  <= n_m;
            r_qm6 <= n_qm;
        end
    end

    // Stage 7: matrix times vector products.
    logic [1:0]         r_f7;
    t_s32               r_oq7 [4];
    t_s32               r_qm7 [4];
    logic               r_z7;
    logic signed [63:0] r_mv7 [9];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f7  <= r_f6;
            r_oq7 <= r_oq6;
            r_qm7 <= r_qm6;
            r_z7  <= r_z6;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mv7[3*i + j] <= smul(r_m6[3*i + j], r_p6[j]);
                end
            end
        end
    end

    // Stage 8: row sums rounded half up to Q16.16.
    logic [1:0]         r_f8;
    t_s32               r_oq8 [4];
    t_s32               r_qm8 [4];
    logic               r_z8;
    logic signed [35:0] r_s8 [3];
    logic signed [65:0] w_rs;
    logic signed [35:0] n_s [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rs = 66'(r_mv7[3*i]) + 66'(r_mv7[3*i + 1]) + 66'(r_mv7[3*i + 2])
                 + 66'sd536870912;
            n_s[i] = w_rs[65:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f8  <= r_f7;
            r_oq8 <= r_oq7;
            r_qm8 <= r_qm7;
            r_z8  <= r_z7;
            r_s8  <= n_s;
        end
    end

    // Result selection by operation.
    logic [223:0] w_data;
    logic         w_flag;
    t_s32         w_ot [3];
    t_s32         w_oq [4];
    t_s32         w_pos [3];
    t_s32         w_neg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pos[i] = sat32(40'(r_cfg_t[i]) + 40'(r_s8[i]));
            w_neg[i] = sat32(-40'(r_s8[i]));
            w_ot[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            w_oq[i] = '0;
        end
        w_flag = 1'b0;
        case (r_f8)
            FUNC_POINT: begin
                w_ot = w_pos;
            end
            FUNC_COMPOSE: begin
                w_ot = w_pos;
                w_oq = r_qm8;
            end
            FUNC_INVERT: begin
                if (r_z8) begin
                    w_flag = 1'b1;
                end else begin
                    w_ot = w_neg;
                    w_oq = r_oq8;
                end
            end
            default: begin
            end
        endcase
        w_data = {w_oq[3], w_oq[2], w_oq[1], w_oq[0], w_ot[2], w_ot[1], w_ot[0]};
    end

    // Output register with a one-entry skid stage behind it.
    logic         r_ov;
    logic         r_skid_v;
    logic [223:0] r_odata;
    logic         r_oflag;
    logic [223:0] r_sdata;
    logic         r_sflag;
    logic         w_take;
    logic         w_inv;

    assign w_en   = !r_skid_v;
    assign w_take = !r_ov || i_m_tready;
    assign w_inv  = w_en && r_v8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_take) begin
            r_ov     <= r_skid_v || w_inv;
            r_skid_v <= 1'b0;
        end else if (w_inv) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_odata <= r_skid_v ? r_sdata : w_data;
            r_oflag <= r_skid_v ? r_sflag : w_flag;
        end else if (w_inv) begin
            r_sdata <= w_data;
            r_sflag <= w_flag;
        end
    end

    assign o_s_tready   = w_en;
    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = r_odata;
    assign o_m_tuser[0] = r_oflag;

    // The skid entry fills only behind a stalled output.
    `QPT_ASSERT(a_skid_fill, $rose(r_skid_v) |-> $past(o_m_tvalid && !i_m_tready), "skid filled without a stalled output")
    // A zero-norm inverse carries all-zero data.
    `QPT_ASSERT(a_zero_norm_data, (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0), "zero-norm result has nonzero data")
    // Reset empties the output side.
    `QPT_ASSERT_RST(a_reset_empty, !i_rst_n |=> (!o_m_tvalid && !r_skid_v), "output not empty after reset")

endmodule

/* rtl/qpt_div.sv */
// Pipelined restoring divider, four lanes sharing one denominator.
module qpt_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [63:0]            i_den,
    input  logic [3:0][31:0]       i_mag,
    input  qpt_pkg::t_div_pay      i_pay,
    output logic                   o_valid,
    output logic [63:0]            o_den,
    output logic [3:0][62:0]       o_rem,
    output logic [3:0][30:0]       o_quo,
    output qpt_pkg::t_div_pay      o_pay
);
    import qpt_pkg::*;

    logic [DIV_STEPS-1:0] r_vld;
    logic [63:0]          r_den [DIV_STEPS];
    logic [3:0][62:0]     r_rem [DIV_STEPS];
    logic [3:0][62:0]     n_rem [DIV_STEPS];
    logic [3:0][30:0]     r_quo [DIV_STEPS];
    logic [3:0][30:0]     n_quo [DIV_STEPS];
    t_div_pay             r_pay [DIV_STEPS];

    // Each stage resolves one quotient bit per lane.
    always_comb begin
        t_div_step st;
        for (int l = 0; l < 4; l++) begin
            st = div_step({3'b000, i_mag[l], 28'd0}, i_den);
            n_rem[0][l] = st.rem;
            n_quo[0][l] = {30'd0, st.bit_q};
        end
        for (int k = 1; k < DIV_STEPS; k++) begin
            for (int l = 0; l < 4; l++) begin
                st = div_step(r_rem[k-1][l], r_den[k-1]);
                n_rem[k][l] = st.rem;
                n_quo[k][l] = {r_quo[k-1][l][29:0], st.bit_q};
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-2:0], i_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_pay[0] <= i_pay;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_den[k] <= r_den[k-1];
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_den   = r_den[DIV_STEPS-1];
    assign o_rem   = r_rem[DIV_STEPS-1];
    assign o_quo   = r_quo[DIV_STEPS-1];
    assign o_pay   = r_pay[DIV_STEPS-1];

endmodule

/* test/tb_quaternion_pose_transform.sv */
// Self-checking testbench for the fixed-point quaternion pose transform.
`timescale 1ns / 1ps

module tb_quaternion_pose_transform;
    import qpt_pkg::*;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] v [3];
        logic signed [31:0] q [4];
    } t_req;

    typedef struct {
        logic signed [31:0] t [3];
        logic signed [31:0] q [4];
        logic               zero_norm;
    } t_pose_out;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [223:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [223:0] o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         i_cfg_wr_en = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wdata = '0;

    quaternion_pose_transform dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configured pose.
    logic signed [31:0] pose_t [3];
    logic signed [31:0] pose_q [4];

    t_req      pending_reqs [$];
    t_pose_out expected_poses [$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        n_results = 0;

    function automatic longint sat_s32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Floor division by 2^n for a signed 128-bit value.
    function automatic logic signed [127:0] floor_shift(input logic signed [127:0] x, int n);
        return x >>> n;
    endfunction

    // Exact sum of products, rounded half up from Q60/Q46 by 2^30.
    function automatic longint round_q30(input logic signed [127:0] s);
        return longint'(floor_shift(s + 128'sd536870912, 30));
    endfunction

    function automatic longint twice_ab(input longint a, input longint b);
        logic signed [127:0] p;
        p = a * b + 128'sd268435456;
        return longint'(floor_shift(p, 29));
    endfunction

    function automatic void rotation_of(input longint q [4], output longint r [9]);
        longint w, x, y, z;
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        r[0] = sat_s32(64'sd1073741824 - twice_ab(y, y) - twice_ab(z, z));
        r[1] = sat_s32(twice_ab(x, y) - twice_ab(z, w));
        r[2] = sat_s32(twice_ab(x, z) + twice_ab(y, w));
        r[3] = sat_s32(twice_ab(x, y) + twice_ab(z, w));
        r[4] = sat_s32(64'sd1073741824 - twice_ab(x, x) - twice_ab(z, z));
        r[5] = sat_s32(twice_ab(y, z) - twice_ab(x, w));
        r[6] = sat_s32(twice_ab(x, z) - twice_ab(y, w));
        r[7] = sat_s32(twice_ab(y, z) + twice_ab(x, w));
        r[8] = sat_s32(64'sd1073741824 - twice_ab(x, x) - twice_ab(y, y));
    endfunction

    // Rotates v by q, then adds the translation or negates the sum.
    function automatic void rotate_vec(input longint q [4], input longint v [3],
                                       input longint t [3], input bit negate,
                                       output longint o [3]);
        longint r [9];
        longint s;
        logic signed [127:0] acc;
        rotation_of(q, r);
        for (int i = 0; i < 3; i++) begin
            acc = 128'(r[3*i]) * v[0] + 128'(r[3*i+1]) * v[1] + 128'(r[3*i+2]) * v[2];
            s = round_q30(acc);
            o[i] = sat_s32(negate ? -s : t[i] + s);
        end
    endfunction

    // round(c * 2^59 / n), ties away from zero, saturated.
    function automatic longint inv_part(input longint c, input logic [127:0] n);
        logic [127:0] m, num, quo, rem;
        bit neg;
        neg = c < 0;
        m = neg ? 128'(-c) : 128'(c);
        if ((m << 28) >= n) return neg ? -64'sd2147483648 : 64'sd2147483647;
        num = m << 59;
        quo = num / n;
        rem = num % n;
        if ((rem << 1) >= n) quo = quo + 1;
        return sat_s32(neg ? -longint'(quo) : longint'(quo));
    endfunction

    function automatic t_pose_out predict_pose(input t_req rq);
        t_pose_out res;
        longint t [3], q [4], v [3], b [4], ot [3], oq [4];
        logic [127:0] n;
        logic signed [127:0] p [4];
        for (int i = 0; i < 3; i++) begin
            t[i] = pose_t[i]; v[i] = rq.v[i]; ot[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            q[i] = pose_q[i]; b[i] = rq.q[i]; oq[i] = 0;
        end
        res.zero_norm = 1'b0;
        case (rq.func)
            FUNC_POINT: rotate_vec(q, v, t, 1'b0, ot);
            FUNC_COMPOSE: begin
                rotate_vec(q, v, t, 1'b0, ot);
                p[0] = 128'(q[0])*b[0] - 128'(q[1])*b[1] - 128'(q[2])*b[2] - 128'(q[3])*b[3];
                p[1] = 128'(q[0])*b[1] + 128'(q[1])*b[0] + 128'(q[2])*b[3] - 128'(q[3])*b[2];
                p[2] = 128'(q[0])*b[2] - 128'(q[1])*b[3] + 128'(q[2])*b[0] + 128'(q[3])*b[1];
                p[3] = 128'(q[0])*b[3] + 128'(q[1])*b[2] - 128'(q[2])*b[1] + 128'(q[3])*b[0];
                for (int i = 0; i < 4; i++) oq[i] = sat_s32(round_q30(p[i]));
            end
            FUNC_INVERT: begin
                n = 0;
                for (int i = 0; i < 4; i++) n += 128'(b[i] * b[i]) >> 1;
                if (n == 0) begin
                    res.zero_norm = 1'b1;
                end else begin
                    oq[0] = inv_part(b[0], n);
                    for (int i = 1; i < 4; i++) oq[i] = inv_part(-b[i], n);
                    rotate_vec(oq, v, t, 1'b1, ot);
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) res.t[i] = ot[i][31:0];
        for (int i = 0; i < 4; i++) res.q[i] = oq[i][31:0];
        return res;
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        t_req rq;
        if (i_rst_n) begin
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    rq = pending_reqs.pop_front();
                    expected_poses.push_back(predict_pose(rq));
                    i_s_tvalid <= 1'b1;
                    i_s_tuser <= rq.func;
                    i_s_tdata <= {rq.q[3], rq.q[2], rq.q[1], rq.q[0],
                                  rq.v[2], rq.v[1], rq.v[0]};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_pose_out exp_r;
        logic [223:0] exp_data;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (expected_poses.size() == 0) begin
                $display("%0t: unexpected result data=%h user=%b", $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                exp_r = expected_poses.pop_front();
                exp_data = {exp_r.q[3], exp_r.q[2], exp_r.q[1], exp_r.q[0],
                            exp_r.t[2], exp_r.t[1], exp_r.t[0]};
                for (int f = 0; f < 7; f++) begin
                    if (o_m_tdata[32*f +: 32] !== exp_data[32*f +: 32]) begin
                        $display("%0t: field %0d expected %h actual %h", $time, f,
                                 exp_data[32*f +: 32], o_m_tdata[32*f +: 32]);
                        errors++;
                    end
                end
                if (o_m_tuser[0] !== exp_r.zero_norm) begin
                    $display("%0t: zero_norm expected %b actual %b", $time,
                             exp_r.zero_norm, o_m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_s32(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 2) - 1;
            2: return (1 << 30) - $urandom_range(0, 1 << 20);
            default: return $signed($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req rq;
        int mode;
        rq.func = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) rq.v[i] = rand_s32($urandom_range(0, 1) ? 0 : 3);
        for (int i = 0; i < 4; i++) rq.q[i] = rand_s32(mode);
        // In mode 2 the scalar part is near one and the vector parts are random, shifted right by four.
        if (mode == 2) for (int i = 1; i < 4; i++) rq.q[i] = $signed($urandom) >>> 4;
        return rq;
    endfunction

    task automatic add_req(input logic [1:0] f, input logic signed [31:0] x,
                           input logic signed [31:0] w, input logic signed [31:0] qv);
        t_req rq;
        rq.func = f;
        for (int i = 0; i < 3; i++) rq.v[i] = x;
        rq.q[0] = w;
        for (int i = 1; i < 4; i++) rq.q[i] = qv;
        pending_reqs.push_back(rq);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic signed [31:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        if (idx <= CFG_TZ) pose_t[idx[1:0]] = val;
        else pose_q[2'(idx - CFG_QW)] = val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Waits until every queued request has been answered, plus pipeline drain.
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_poses.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_pose(input logic signed [31:0] t, input logic signed [31:0] w,
                            input logic signed [31:0] qv);
        write_reg(CFG_TX, t);
        write_reg(CFG_TY, -t);
        write_reg(CFG_TZ, t >>> 1);
        write_reg(CFG_QW, w);
        write_reg(CFG_QX, qv);
        write_reg(CFG_QY, -qv);
        write_reg(CFG_QZ, qv >>> 1);
    endtask

    initial begin
        pose_t = '{0, 0, 0};
        pose_q = '{ONE_Q30, 0, 0, 0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, zero norm and unused selector.
        add_req(FUNC_POINT, 32'sh0001_0000, 0, 0);
        add_req(FUNC_POINT, S32_MAX, 0, 0);
        add_req(FUNC_POINT, S32_MIN, 0, 0);
        add_req(FUNC_COMPOSE, 32'sh0002_0000, ONE_Q30, 0);
        add_req(FUNC_COMPOSE, S32_MAX, S32_MAX, S32_MAX);
        add_req(FUNC_COMPOSE, S32_MIN, S32_MIN, S32_MIN);
        add_req(FUNC_INVERT, 32'sh0003_0000, ONE_Q30, 0);
        add_req(FUNC_INVERT, S32_MAX, 0, 0);
        add_req(FUNC_INVERT, 32'sh0001_0000, -1, 1);
        add_req(FUNC_INVERT, 32'sh0001_0000, 2, 0);
        add_req(FUNC_INVERT, S32_MIN, S32_MIN, S32_MIN);
        add_req(FUNC_INVERT, 32'sh0001_0000, 32'sh0000_4000, 32'sh0000_2000);
        add_req(2'd3, S32_MAX, S32_MAX, S32_MAX);
        drain();

        // Random phases with different poses and handshake pressure.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                3: begin send_idle_pct = 15; recv_stall_pct = 15; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            case (ph)
                0: set_pose(32'sh0010_0000, 32'sh2d41_3ccd, 32'sh1000_0000);
                1: set_pose(S32_MAX, S32_MAX, S32_MAX);
                2: set_pose(S32_MIN, S32_MIN, S32_MIN);
                3: set_pose(32'sh0000_0000, 32'sh4000_0000, 32'sh0000_0000);
                default: set_pose($urandom, $urandom, $urandom);
            endcase
            for (int k = 0; k < 100; k++) pending_reqs.push_back(rand_req());
            drain();
        end

        $display("Covered point, compose, invert and unused selector requests over six poses,");
        $display("%0d results checked under mixed sender idling and receiver stalls.", n_results);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
